[hdl/assert_macros.svh]
// Assertion macros for the checker file of the peak picker.
// Plain header, no dependencies; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held low.
`define OPP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define OPP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/opp_pkg.sv]
// Package for the onset peak picker: sequencer state type, register indexes,
// reset values and the post-window clamp. No dependencies.
package opp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_XCAP,
        ST_WALK,
        ST_DECIDE,
        ST_PUSH,
        ST_DONE
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 5;
    localparam int GAP_W      = 8;
    localparam int DELTA_W    = 16;
    localparam int PEND_W     = 5;
    localparam int DIST_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_AVG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_AVG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA    = 3'd5;

    localparam logic [WIN_W-1:0]   RST_PRE_MAX  = 5'd1;
    localparam logic [WIN_W-1:0]   RST_POST_MAX = 5'd1;
    localparam logic [WIN_W-1:0]   RST_PRE_AVG  = 5'd6;
    localparam logic [WIN_W-1:0]   RST_POST_AVG = 5'd7;
    localparam logic [GAP_W-1:0]   RST_MIN_GAP  = 8'd1;
    // 0.07 in unsigned Q1.15
    localparam logic [DELTA_W-1:0] RST_DELTA    = 16'd2294;

    localparam logic [PEND_W-1:0]  MAX_PEND     = 5'd16;

    // Post lengths outside 1..16 saturate.
    function automatic logic [WIN_W-1:0] clamp_post(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v == '0) begin
            r = 5'd1;
        end else if (v > 5'd16) begin
            r = 5'd16;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/opp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module opp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/onset_peak_picker.sv]
// Onset peak picker: an item is taken while idle, then each decided frame is judged by
// walking W frames back through the ring, W being the span of the max and mean windows
// (up to 47); up to 16 decisions on the final frame. The walk reads the frames one at a
// time through the single ring read port.
// Reset (synchronous, active low) clears the sequencer, counters and registers;
// the frame ring is not cleared and needs no clearing pass.
module onset_peak_picker
    import opp_pkg::*;
#(
    parameter int RING_DEPTH  = 64,
    parameter int INDEX_BITS  = 20,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_envelope_sample,
    input  logic                   i_is_final,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [INDEX_BITS-1:0]  o_onset_index,
    output logic                   o_onset_valid,
    output logic                   o_end_of_run
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int IW   = INDEX_BITS;
    localparam int SW   = SAMPLE_BITS;
    localparam int XW   = ((SW > DELTA_W) ? SW : DELTA_W) + 2;
    localparam int ACCW = XW + DIST_W;

    // configuration
    logic [WIN_W-1:0]   r_pre_max, r_post_max, r_pre_avg, r_post_avg;
    logic [GAP_W-1:0]   r_min_gap;
    logic [DELTA_W-1:0] r_delta;

    // stream state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head;
    logic [IW-1:0]    r_count, r_last, r_next, r_newest, r_cand, r_hold_idx;
    logic             r_have, r_wrapped, r_final, r_hold_v;
    logic [PEND_W-1:0] r_pend;

    // window walk
    logic [DIST_W-1:0]  r_max_lo, r_max_hi, r_avg_lo, r_avg_hi, r_dhi, r_d, r_tag_d;
    logic [AW-1:0]      r_addr;
    logic               r_tag_v, r_fail;
    logic [SW-1:0]      r_x;
    logic signed [XW-1:0]   r_xd;
    logic signed [ACCW-1:0] r_acc;

    // output register
    logic             r_out_v, r_out_ov, r_out_eor;
    logic [IW-1:0]    r_out_idx;

    // ring memory
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [SW-1:0]    ram_rdata;

    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] h,
                                                input logic [DIST_W-1:0] d);
        logic [AW:0] hx;
        logic [AW:0] dx;
        logic [AW:0] r;
        hx = {1'b0, h};
        dx = (AW+1)'(d);
        if (hx >= dx) begin
            r = hx - dx;
        end else begin
            r = hx + (AW+1)'(RING_DEPTH) - dx;
        end
        return r[AW-1:0];
    endfunction

    opp_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_envelope_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- combinational helpers ----------------
    logic              in_acc, slot_free, go, onset, blocked;
    logic [AW-1:0]     head_inc;
    logic [IW-1:0]     count_inc, pend_full, gap;
    logic [WIN_W-1:0]  cpm, cpa, look;
    logic [3:0]        d0, fm, fa;
    logic [WIN_W-1:0]  bm, ba;
    logic [DIST_W-1:0] max_lo, max_hi, avg_lo, avg_hi;
    logic [SW-1:0]     s;
    logic signed [XW-1:0] term;
    logic              in_max, in_avg;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_v || i_out_ready;
    assign head_inc  = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign pend_full = r_count - r_next + 1'b1;

    assign cpm  = clamp_post(r_post_max);
    assign cpa  = clamp_post(r_post_avg);
    assign look = (cpa > cpm) ? cpa : cpm;
    assign go   = (r_pend != '0) && (r_final || r_pend >= look);

    always_comb begin
        d0 = 4'(r_pend - 1'b1);
        fm = 4'(cpm - 1'b1);
        fa = 4'(cpa - 1'b1);
        if (fm > d0) fm = d0;
        if (fa > d0) fa = d0;
        bm = r_pre_max;
        ba = r_pre_avg;
        // cut windows at the stream start until the count wraps
        if (!r_wrapped && r_next < IW'(r_pre_max)) bm = r_next[WIN_W-1:0];
        if (!r_wrapped && r_next < IW'(r_pre_avg)) ba = r_next[WIN_W-1:0];
        max_lo = DIST_W'(d0) - DIST_W'(fm);
        max_hi = DIST_W'(d0) + DIST_W'(bm);
        avg_lo = DIST_W'(d0) - DIST_W'(fa);
        avg_hi = DIST_W'(d0) + DIST_W'(ba);
    end

    assign s      = ram_rdata;
    assign term   = r_xd - $signed({{(XW-SW){1'b0}}, s});
    assign in_max = (r_tag_d >= r_max_lo) && (r_tag_d <= r_max_hi);
    assign in_avg = (r_tag_d >= r_avg_lo) && (r_tag_d <= r_avg_hi);

    assign gap     = r_next - r_last;
    assign blocked = r_have && (gap <= IW'(r_min_gap));
    assign onset   = !r_fail && !r_acc[ACCW-1] && !blocked;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_CHECK;
            ST_CHECK:  n_state = go ? ST_SETUP : ST_DONE;
            ST_SETUP:  n_state = ST_XCAP;
            ST_XCAP:   n_state = ST_WALK;
            ST_WALK:   if (r_d > r_dhi && !r_tag_v) n_state = ST_DECIDE;
            ST_DECIDE: n_state = onset ? ST_PUSH : ST_CHECK;
            ST_PUSH:   if (!r_hold_v || slot_free) n_state = ST_CHECK;
            ST_DONE: begin
                if (slot_free || (!r_final && !r_hold_v)) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    logic out_load, out_ov, out_eor;
    logic [IW-1:0] out_idx;

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = head_inc;
        ram_re     = 1'b0;
        ram_raddr  = r_addr;
        out_load   = 1'b0;
        out_idx    = r_hold_idx;
        out_ov     = 1'b1;
        out_eor    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_we     = i_in_valid;
            end
            ST_SETUP: begin
                ram_re    = 1'b1;
                ram_raddr = ring_back(r_head, DIST_W'(d0));
            end
            ST_WALK: begin
                ram_re = (r_d <= r_dhi);
            end
            ST_PUSH: begin
                out_load = r_hold_v && slot_free;
            end
            ST_DONE: begin
                out_load = slot_free && (r_final || r_hold_v);
                out_eor  = r_final;
                out_ov   = r_hold_v;
                out_idx  = r_hold_v ? r_hold_idx : r_newest;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pre_max  <= RST_PRE_MAX;
            r_post_max <= RST_POST_MAX;
            r_pre_avg  <= RST_PRE_AVG;
            r_post_avg <= RST_POST_AVG;
            r_min_gap  <= RST_MIN_GAP;
            r_delta    <= RST_DELTA;
            r_head     <= '0;
            r_count    <= '0;
            r_last     <= '0;
            r_next     <= '0;
            r_have     <= 1'b0;
            r_wrapped  <= 1'b0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_tag_v    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRE_MAX:  r_pre_max  <= i_cfg_data[WIN_W-1:0];
                    CFG_POST_MAX: r_post_max <= i_cfg_data[WIN_W-1:0];
                    CFG_PRE_AVG:  r_pre_avg  <= i_cfg_data[WIN_W-1:0];
                    CFG_POST_AVG: r_post_avg <= i_cfg_data[WIN_W-1:0];
                    CFG_MIN_GAP:  r_min_gap  <= i_cfg_data[GAP_W-1:0];
                    CFG_DELTA:    r_delta    <= i_cfg_data[DELTA_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_head    <= head_inc;
                        r_count   <= count_inc;
                        if (count_inc == '0) r_wrapped <= 1'b1;
                        r_newest  <= r_count;
                        r_final   <= i_is_final;
                        r_pend    <= (pend_full > IW'(MAX_PEND)) ? MAX_PEND
                                                               : pend_full[PEND_W-1:0];
                    end
                end
                ST_CHECK: ;
                ST_SETUP: begin
                    r_max_lo <= max_lo;
                    r_max_hi <= max_hi;
                    r_avg_lo <= avg_lo;
                    r_avg_hi <= avg_hi;
                    r_dhi    <= (max_hi > avg_hi) ? max_hi : avg_hi;
                    r_d      <= (max_lo < avg_lo) ? max_lo : avg_lo;
                end
                ST_XCAP: begin
                    // candidate frame is on the read port now
                    r_x     <= ram_rdata;
                    r_xd    <= $signed({{(XW-SW){1'b0}}, ram_rdata})
                             - $signed({{(XW-DELTA_W){1'b0}}, r_delta});
                    r_addr  <= ring_back(r_head, r_d);
                    r_fail  <= 1'b0;
                    r_acc   <= '0;
                    r_tag_v <= 1'b0;
                end
                ST_WALK: begin
                    // issue one ring read a cycle, walking back in time
                    if (r_d <= r_dhi) begin
                        r_tag_v <= 1'b1;
                        r_tag_d <= r_d;
                        r_d     <= r_d + 1'b1;
                        r_addr  <= (r_addr == '0) ? AW'(RING_DEPTH - 1) : r_addr - 1'b1;
                    end else begin
                        r_tag_v <= 1'b0;
                    end
                    if (r_tag_v) begin
                        if (in_max && s > r_x) r_fail <= 1'b1;
                        if (in_avg) r_acc <= r_acc + ACCW'(term);
                    end
                end
                ST_DECIDE: begin
                    if (onset) begin
                        r_last <= r_next;
                        r_have <= 1'b1;
                        r_cand <= r_next;
                    end
                    r_next <= r_next + 1'b1;
                    r_pend <= r_pend - 1'b1;
                end
                ST_PUSH: begin
                    // keep the newest onset back so the final one can carry end of run
                    if (!r_hold_v || slot_free) begin
                        r_hold_v   <= 1'b1;
                        r_hold_idx <= r_cand;
                    end
                end
                ST_DONE: begin
                    if (out_load) r_hold_v <= 1'b0;
                    if (out_load && r_final) begin
                        r_count   <= '0;
                        r_last    <= '0;
                        r_have    <= 1'b0;
                        r_next    <= '0;
                        r_wrapped <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx <= out_idx;
            r_out_ov  <= out_ov;
            r_out_eor <= out_eor;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_onset_index = r_out_idx;
    assign o_onset_valid = r_out_ov;
    assign o_end_of_run  = r_out_eor;

endmodule

[hdl/opp_checker.sv]
// Port-level checker for the onset peak picker, bound to the top level below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module opp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_onset_valid,
    input logic o_end_of_run
);

    // a bare end marker always closes the run
    `OPP_ASSERT(a_marker_eor, i_clk, i_rst_n, (o_out_valid && !o_onset_valid) |-> o_end_of_run, "end marker without end of run")

    // the sequencer is busy right after it takes a request
    `OPP_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready held after a request")

    // a waiting result is held until taken
    `OPP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "result dropped before taken")

    // reset empties the output register
    `OPP_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind onset_peak_picker opp_checker u_opp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_onset_valid (o_onset_valid),
    .o_end_of_run  (o_end_of_run)
);

[sim/tb_onset_peak_picker.sv]
// Testbench for onset_peak_picker: streams envelope frames through the block, predicts
// the onsets in a small scoreboard class and checks every result against it.
// Depends on opp_pkg and the onset_peak_picker RTL.

import opp_pkg::*;

typedef struct packed {
    logic [19:0] index;
    logic        valid;
    logic        eor;
} onset_t;

class onset_tracker;
    bit [15:0] ring [64];
    bit [5:0]  head;
    bit [19:0] frame_no;
    bit [19:0] next_undecided;
    bit [19:0] last_onset;
    bit        have_onset;
    bit        wrapped;
    bit [4:0]  pre_max, post_max, pre_avg, post_avg;
    bit [7:0]  min_gap;
    bit [15:0] delta;
    onset_t    pending_onsets[$];
    int        mismatches;

    function new();
        pre_max  = RST_PRE_MAX;
        post_max = RST_POST_MAX;
        pre_avg  = RST_PRE_AVG;
        post_avg = RST_POST_AVG;
        min_gap  = RST_MIN_GAP;
        delta    = RST_DELTA;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PRE_MAX:  pre_max  = data[4:0];
            CFG_POST_MAX: post_max = data[4:0];
            CFG_PRE_AVG:  pre_avg  = data[4:0];
            CFG_POST_AVG: post_avg = data[4:0];
            CFG_MIN_GAP:  min_gap  = data[7:0];
            CFG_DELTA:    delta    = data[15:0];
            default: ;
        endcase
    endfunction

    function int sat_post(bit [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return v;
    endfunction

    function bit [15:0] frame_at(int d);
        return ring[6'(int'(head) - d)];
    endfunction

    // Candidate i sits d0 frames behind the newest stored frame.
    function bit is_onset(bit [19:0] i, int d0);
        bit [15:0] x;
        bit [19:0] gap;
        int        bm, ba, fm, fa, cnt, d;
        longint    acc;
        x  = frame_at(d0);
        bm = pre_max;
        ba = pre_avg;
        fm = sat_post(post_max) - 1;
        fa = sat_post(post_avg) - 1;
        // cut the windows at the stream start
        if (!wrapped) begin
            if (i < bm) bm = i;
            if (i < ba) ba = i;
        end
        if (fm > d0) fm = d0;
        if (fa > d0) fa = d0;
        for (d = d0 - fm; d <= d0 + bm; d++)
            if (frame_at(d) > x) return 1'b0;
        acc = 0;
        cnt = 0;
        for (d = d0 - fa; d <= d0 + ba; d++) begin
            acc += frame_at(d);
            cnt++;
        end
        if (longint'(x) * cnt < acc + longint'(delta) * cnt) return 1'b0;
        gap = i - last_onset;
        if (have_onset && gap <= min_gap) return 1'b0;
        return 1'b1;
    endfunction

    function void take_frame(bit [15:0] s, bit is_end);
        bit [19:0] newest, span;
        bit [19:0] hits[$];
        int        look, pending;
        newest = frame_no;
        head++;
        ring[head] = s;
        frame_no++;
        if (frame_no == 0) wrapped = 1'b1;
        look = (sat_post(post_max) > sat_post(post_avg)) ? sat_post(post_max)
                                                          : sat_post(post_avg);
        span    = newest - next_undecided + 20'd1;
        pending = (span > 16) ? 16 : int'(span);
        // the final frame flushes everything still waiting
        while (pending > 0 && (is_end || pending >= look)) begin
            if (is_onset(next_undecided, pending - 1)) begin
                hits.push_back(next_undecided);
                last_onset = next_undecided;
                have_onset = 1'b1;
            end
            next_undecided++;
            pending--;
        end
        if (is_end && hits.size() == 0)
            pending_onsets.push_back(onset_t'{newest, 1'b0, 1'b1});
        foreach (hits[k])
            pending_onsets.push_back(onset_t'{hits[k], 1'b1, is_end && k == hits.size() - 1});
        if (is_end) begin
            frame_no       = '0;
            next_undecided = '0;
            last_onset     = '0;
            have_onset     = 1'b0;
            wrapped        = 1'b0;
        end
    endfunction

    function void match_onset(onset_t got);
        onset_t want;
        if (pending_onsets.size() == 0) begin
            $error("unexpected onset result: index %0d valid %0b end %0b",
                   got.index, got.valid, got.eor);
            mismatches++;
            return;
        end
        want = pending_onsets.pop_front();
        if (got.index !== want.index) begin
            $error("onset_index: expected %0d, got %0d", want.index, got.index);
            mismatches++;
        end
        if (got.valid !== want.valid) begin
            $error("onset_valid: expected %0b, got %0b", want.valid, got.valid);
            mismatches++;
        end
        if (got.eor !== want.eor) begin
            $error("end_of_run: expected %0b, got %0b", want.eor, got.eor);
            mismatches++;
        end
    endfunction
endclass

module tb_onset_peak_picker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_FRAMES = 430;
    localparam int SETTLE_CYCLES = 1000;
    localparam int LONG_HOLD     = 3000;
    localparam int STALL_LIMIT   = 20000;

    localparam logic [15:0] RISE_FALL [8] = '{16'd32768, 16'd0, 16'd0, 16'd32768,
                                              16'd32768, 16'd0, 16'd1, 16'd0};

    typedef struct packed {
        logic [4:0]  pre_max;
        logic [4:0]  post_max;
        logic [4:0]  pre_avg;
        logic [4:0]  post_avg;
        logic [7:0]  min_gap;
        logic [15:0] delta;
    } picker_cfg_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_TOGGLE, RX_HEAVY, RX_BEAT} rx_mode_t;
    typedef enum {STYLE_SPIKY, STYLE_FULL, STYLE_STEPS, STYLE_BINARY} env_style_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_PRE_MAX;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [15:0]           env_sample = '0;
    logic                  is_last    = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [19:0]           onset_index;
    logic                  onset_valid;
    logic                  end_of_run;

    int           hold_asked = 0;
    onset_tracker tracker    = new();

    onset_peak_picker u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_envelope_sample (env_sample),
        .i_is_final        (is_last),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_onset_index     (onset_index),
        .o_onset_valid     (onset_valid),
        .o_end_of_run      (end_of_run)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            tracker.take_frame(env_sample, is_last);
        if (rst_n && out_valid && out_ready)
            tracker.match_onset(onset_t'{onset_index, onset_valid, end_of_run});
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: a pattern of its own, plus a long hold-off on request.
    initial begin
        int       holds_done, tick;
        rx_mode_t mode;
        holds_done = 0;
        tick       = 0;
        mode       = RX_OPEN;
        forever begin
            @(posedge clk);
            if (hold_asked != holds_done) begin
                holds_done = hold_asked;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (tick == 0) begin
                mode = rx_mode_t'($urandom_range(0, 4));
                tick = $urandom_range(50, 400);
            end
            tick--;
            case (mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: out_ready <= ~out_ready;
                RX_HEAVY:  out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ((tick % 16) < 10);
            endcase
        end
    end

    task automatic send_frame(input logic [15:0] v, input logic fin);
        in_valid   <= 1'b1;
        env_sample <= v;
        is_last    <= fin;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // Drop valid and let the block drain before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_onsets.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic apply_cfg(input picker_cfg_t c);
        write_reg(CFG_PRE_MAX,  16'(c.pre_max));
        write_reg(CFG_POST_MAX, 16'(c.post_max));
        write_reg(CFG_PRE_AVG,  16'(c.pre_avg));
        write_reg(CFG_POST_AVG, 16'(c.post_avg));
        write_reg(CFG_MIN_GAP,  16'(c.min_gap));
        write_reg(CFG_DELTA,    c.delta);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [4:0] pick_post();
        if ($urandom_range(0, 4) == 0)
            return ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
        return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(7, 16))
                                           : 5'($urandom_range(1, 6));
    endfunction

    function automatic logic [4:0] pick_pre();
        if ($urandom_range(0, 5) == 0)
            return ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd31;
        return 5'($urandom_range(0, 12));
    endfunction

    function automatic picker_cfg_t pick_cfg(int n);
        picker_cfg_t c;
        case (n)
            0: c = '{pre_max: 5'd3, post_max: 5'd16, pre_avg: 5'd10, post_avg: 5'd16,
                     min_gap: 8'd2, delta: 16'd1000};
            // much shorter lookahead: the open stream decides a backlog at once
            1: c = '{pre_max: 5'd2, post_max: 5'd1, pre_avg: 5'd4, post_avg: 5'd1,
                     min_gap: 8'd0, delta: 16'd200};
            default: begin
                c.pre_max  = pick_pre();
                c.post_max = pick_post();
                c.pre_avg  = pick_pre();
                c.post_avg = pick_post();
                case ($urandom_range(0, 5))
                    0:       c.min_gap = 8'd255;
                    1:       c.min_gap = 8'($urandom_range(0, 255));
                    default: c.min_gap = 8'($urandom_range(0, 6));
                endcase
                case ($urandom_range(0, 6))
                    0:       c.delta = 16'd0;
                    1:       c.delta = 16'd32768;
                    2:       c.delta = 16'($urandom_range(0, 32768));
                    default: c.delta = 16'($urandom_range(0, 4000));
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic int pick_stream_len();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return $urandom_range(2, 4);
            8, 9:    return $urandom_range(41, 90);
            default: return $urandom_range(5, 40);
        endcase
    endfunction

    initial begin
        int          sent, phase_no, phase_left, stream_left, burst_left, gap;
        env_style_t  style;
        logic [15:0] v, level;
        sent        = 0;
        phase_no    = 0;
        stream_left = 0;
        style       = STYLE_SPIKY;
        level       = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: a lone final frame, then sharp peaks and a plateau.
        send_frame(16'd0, 1'b1);
        for (int k = 0; k < 8; k++)
            send_frame(RISE_FALL[k], k == 7);

        // Widest windows, widest spacing, no margin over a flat stream.
        settle();
        apply_cfg('{pre_max: 5'd31, post_max: 5'd16, pre_avg: 5'd31, post_avg: 5'd16,
                    min_gap: 8'd255, delta: 16'd0});
        for (int k = 0; k < 7; k++)
            send_frame((k == 6) ? 16'd0 : 16'd500, k == 6);

        // Post lengths out of range, empty pre windows, full margin.
        settle();
        apply_cfg('{pre_max: 5'd0, post_max: 5'd0, pre_avg: 5'd0, post_avg: 5'd31,
                    min_gap: 8'd0, delta: 16'd32768});
        send_frame(16'd32768, 1'b0);
        send_frame(16'd0,     1'b0);
        send_frame(16'd32768, 1'b0);
        send_frame(16'd32768, 1'b0);
        send_frame(16'd0,     1'b1);

        while (sent < RANDOM_FRAMES || stream_left != 0) begin
            settle();
            apply_cfg(pick_cfg(phase_no));
            if (phase_no == 1 || phase_no == 4)
                hold_asked++;
            phase_left = $urandom_range(25, 70);
            burst_left = $urandom_range(1, 20);
            while (phase_left > 0 && (sent < RANDOM_FRAMES || stream_left != 0)) begin
                if (stream_left == 0) begin
                    // keep the first stream open into the next setting
                    stream_left = (sent == 0) ? phase_left + $urandom_range(5, 20)
                                              : pick_stream_len();
                    case ($urandom_range(0, 7))
                        0, 1:    style = STYLE_FULL;
                        2:       style = STYLE_STEPS;
                        3:       style = STYLE_BINARY;
                        default: style = STYLE_SPIKY;
                    endcase
                    level = 16'($urandom_range(0, 32768));
                end
                case (style)
                    STYLE_FULL:   v = 16'($urandom_range(0, 32768));
                    STYLE_BINARY: v = ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'd0;
                    STYLE_STEPS: begin
                        if ($urandom_range(0, 7) == 0)
                            level = 16'($urandom_range(0, 32768));
                        v = level;
                    end
                    default: begin
                        if ($urandom_range(0, 5) != 0)
                            v = 16'($urandom_range(0, 3000));
                        else if ($urandom_range(0, 3) == 0)
                            v = 16'd32768;
                        else
                            v = 16'($urandom_range(8000, 32768));
                    end
                endcase
                send_frame(v, stream_left == 1);
                stream_left--;
                sent++;
                phase_left--;
                burst_left--;
                if (burst_left == 0 && phase_left > 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 30);
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end
            phase_no++;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending_onsets.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
